/* src/imu_fd_pkg.sv */
// Shared types and constants for the IMU fall detector.
// Used by the front end, the sample queue, the back end and the top level.
// No dependencies.
package imu_fd_pkg;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 19;

	localparam logic [CFG_IDX_W-1:0] CFG_FREEFALL    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMPACT      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIENTATION = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_IMMOBILITY  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD        = 3'd4;

	localparam logic [13:0] FREEFALL_RST    = 14'd500;
	localparam logic [14:0] IMPACT_RST      = 15'd2500;
	localparam logic [18:0] ORIENTATION_RST = 19'd45000;
	localparam logic [7:0]  IMMOBILITY_RST  = 8'd10;
	localparam logic [7:0]  HOLD_RST        = 8'd5;

	// Gyro magnitude to millidegrees per 10 ms sample, Q16
	localparam logic [15:0] TURN_GAIN = 16'd37549;

	// Still band around 1 g: |A - 1000| < 300
	localparam logic [15:0] STILL_LO_MG = 16'd700;
	localparam logic [15:0] STILL_HI_MG = 16'd1300;

	// Reported detector state codes
	localparam logic [2:0] DET_MONITOR   = 3'd0;
	localparam logic [2:0] DET_FREEFALL  = 3'd1;
	localparam logic [2:0] DET_VERIFY    = 3'd2;
	localparam logic [2:0] DET_CONFIRMED = 3'd3;
	localparam logic [2:0] DET_FALSE     = 3'd4;

	// One preprocessed sample travelling from front to back
	typedef struct packed {
		logic [15:0] amag;
		logic [15:0] step;
		logic [31:0] time_ms;
	} item_t;

	// Configuration register set
	typedef struct packed {
		logic [13:0] freefall_mg;
		logic [14:0] impact_mg;
		logic [18:0] orientation_mdeg;
		logic [7:0]  immobility_s;
		logic [7:0]  hold_s;
	} cfg_t;

endpackage

/* src/imu_fd_front.sv */
// Front end: accepts IMU samples, squares and sums both vectors with one
// shared multiplier, takes two bit-serial square roots and scales the gyro
// magnitude to an orientation step. Depends on imu_fd_pkg.
module imu_fd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic signed [15:0]  accel_x,
	input  logic signed [15:0]  accel_y,
	input  logic signed [15:0]  accel_z,
	input  logic signed [15:0]  rate_x,
	input  logic signed [15:0]  rate_y,
	input  logic signed [15:0]  rate_z,
	input  logic [31:0]         time_ms,
	output logic                push,
	input  logic                push_ready,
	output imu_fd_pkg::item_t   push_item
);
	import imu_fd_pkg::*;

	typedef enum logic [4:0] {
		F_IDLE  = 5'b00001,
		F_SQ    = 5'b00010,
		F_ROOT  = 5'b00100,
		F_SCALE = 5'b01000,
		F_PUSH  = 5'b10000
	} fstate_t;

	typedef struct packed {
		logic [17:0] rem;
		logic [15:0] root;
	} root_t;

	// One digit of the restoring square root
	function automatic root_t root_step(root_t s, logic [1:0] pair);
		logic [19:0] rem_sh;
		logic [19:0] trial;
		root_t       r;
		rem_sh = {s.rem, pair};
		trial  = {2'b00, s.root, 2'b01};
		if (rem_sh >= trial) begin
			r.rem  = 18'(rem_sh - trial);
			r.root = {s.root[14:0], 1'b1};
		end else begin
			r.rem  = 18'(rem_sh);
			r.root = {s.root[14:0], 1'b0};
		end
		return r;
	endfunction

	fstate_t            fst_q;
	logic signed [15:0] ops_q [6];
	logic [31:0]        time_q;
	logic [3:0]         cnt_q;
	logic [31:0]        prod_q;
	logic [31:0]        asum_q;
	logic [31:0]        wsum_q;
	root_t              aroot_q;
	root_t              wroot_q;
	logic [15:0]        step_q;

	logic signed [31:0] sq;
	logic [31:0]        scaled;
	root_t              anext;
	root_t              wnext;

	assign sq     = ops_q[0] * ops_q[0];
	assign scaled = wroot_q.root * TURN_GAIN;
	assign anext  = root_step(aroot_q, asum_q[31:30]);
	assign wnext  = root_step(wroot_q, wsum_q[31:30]);

	assign in_ready  = (fst_q == F_IDLE);
	assign push      = (fst_q == F_PUSH);
	assign push_item = '{amag: aroot_q.root, step: step_q, time_ms: time_q};

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fst_q <= F_IDLE;
			cnt_q <= '0;
		end else begin
			unique case (fst_q)
				F_IDLE: begin
					cnt_q <= '0;
					if (in_valid) fst_q <= F_SQ;
				end
				F_SQ: begin
					if (cnt_q == 4'd6) begin
						cnt_q <= '0;
						fst_q <= F_ROOT;
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				F_ROOT: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd15) fst_q <= F_SCALE;
				end
				F_SCALE: fst_q <= F_PUSH;
				F_PUSH: if (push_ready) fst_q <= F_IDLE;
				default: fst_q <= F_IDLE;
			endcase
		end
	end

	// Datapath: operand shift line, squares, sums, roots, scaling
	always_ff @(posedge clk) begin
		case (fst_q)
			F_IDLE: begin
				ops_q[0] <= accel_x;
				ops_q[1] <= accel_y;
				ops_q[2] <= accel_z;
				ops_q[3] <= rate_x;
				ops_q[4] <= rate_y;
				ops_q[5] <= rate_z;
				time_q   <= time_ms;
				asum_q   <= '0;
				wsum_q   <= '0;
			end
			F_SQ: begin
				for (int i = 0; i < 5; i++) ops_q[i] <= ops_q[i+1];
				prod_q <= unsigned'(sq);
				if (cnt_q >= 4'd1 && cnt_q <= 4'd3) asum_q <= asum_q + prod_q;
				if (cnt_q >= 4'd4) wsum_q <= wsum_q + prod_q;
				aroot_q <= '0;
				wroot_q <= '0;
			end
			F_ROOT: begin
				aroot_q <= anext;
				wroot_q <= wnext;
				asum_q  <= {asum_q[29:0], 2'b00};
				wsum_q  <= {wsum_q[29:0], 2'b00};
			end
			F_SCALE: step_q <= scaled[31:16];
			default: ;
		endcase
	end

endmodule

/* src/imu_fd_queue.sv */
// Two-entry queue of preprocessed samples between front and back end.
// Depends on imu_fd_pkg for the entry type.
module imu_fd_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              push_ready,
	input  imu_fd_pkg::item_t push_item,
	output logic              pop_valid,
	input  logic              pop,
	output imu_fd_pkg::item_t pop_item
);
	import imu_fd_pkg::*;

	item_t       slot_q [2];
	logic        wr_q;
	logic        rd_q;
	logic [1:0]  cnt_q;
	logic        do_push;
	logic        do_pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_item   = slot_q[rd_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= ~wr_q;
			if (do_pop) rd_q <= ~rd_q;
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: ;
			endcase
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_q] <= push_item;
	end

endmodule

/* src/imu_fd_back.sv */
// Back end: runs the fall state machine on preprocessed samples and holds
// the result transaction in an output register. Depends on imu_fd_pkg.
module imu_fd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  imu_fd_pkg::cfg_t  cfg,
	input  logic              pop_valid,
	output logic              pop,
	input  imu_fd_pkg::item_t pop_item,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [2:0]        detector_state,
	output logic              fall_confirmed,
	output logic [15:0]       accel_magnitude_mg,
	output logic [15:0]       peak_impact_mg,
	output logic [31:0]       orientation_mdeg,
	output logic [31:0]       freefall_span_ms,
	output logic [31:0]       falls_total
);
	import imu_fd_pkg::*;

	typedef enum logic [1:0] {
		B_LOAD = 2'b01,
		B_EVAL = 2'b10
	} bstate_t;

	typedef enum logic [4:0] {
		MD_MONITOR   = 5'b00001,
		MD_FREEFALL  = 5'b00010,
		MD_VERIFY    = 5'b00100,
		MD_CONFIRMED = 5'b01000,
		MD_FALSE     = 5'b10000
	} mode_t;

	bstate_t     bst_q;
	mode_t       mode_q;
	logic [31:0] ffstart_q;
	logic [31:0] impact_q;
	logic [15:0] peak_q;
	logic [31:0] turn_q;
	logic [31:0] tally_q;
	logic [17:0] immo_ms_q;
	logic [17:0] hold_ms_q;
	item_t       cur_s1;
	logic [31:0] delta_s1;
	logic        out_valid_q;

	mode_t       mode_d;
	logic [31:0] ffstart_d;
	logic [31:0] impact_d;
	logic [15:0] peak_d;
	logic [31:0] turn_d;
	logic [31:0] tally_d;
	logic        pulse_d;
	logic [31:0] dur_d;
	logic [32:0] turn_sum;
	logic [2:0]  code_d;
	logic [17:0] immo_ext;
	logic [17:0] hold_ext;
	logic        slot_free;
	logic        commit;

	assign slot_free = !out_valid_q || out_ready;
	assign commit    = (bst_q == B_EVAL) && slot_free;
	assign pop       = (bst_q == B_LOAD) && pop_valid;
	assign out_valid = out_valid_q;
	assign immo_ext  = {10'd0, cfg.immobility_s};
	assign hold_ext  = {10'd0, cfg.hold_s};
	assign turn_sum  = {1'b0, turn_q} + {17'd0, cur_s1.step};

	// Seconds to milliseconds: x*1000 = x*1024 - x*16 - x*8
	always_ff @(posedge clk) begin
		immo_ms_q <= (immo_ext << 10) - (immo_ext << 4) - (immo_ext << 3);
		hold_ms_q <= (hold_ext << 10) - (hold_ext << 4) - (hold_ext << 3);
	end

	// Next detector state for the sample in cur_s1
	always_comb begin
		mode_d    = mode_q;
		ffstart_d = ffstart_q;
		impact_d  = impact_q;
		peak_d    = peak_q;
		turn_d    = turn_q;
		tally_d   = tally_q;
		pulse_d   = 1'b0;
		dur_d     = '0;
		unique case (mode_q)
			MD_MONITOR: begin
				if (cur_s1.amag < {2'b00, cfg.freefall_mg}) begin
					mode_d    = MD_FREEFALL;
					ffstart_d = cur_s1.time_ms;
				end
			end
			MD_FREEFALL: begin
				if (cur_s1.amag > {1'b0, cfg.impact_mg}) begin
					impact_d = cur_s1.time_ms;
					peak_d   = cur_s1.amag;
					turn_d   = {16'd0, cur_s1.step};
					mode_d   = MD_VERIFY;
				end else if (cur_s1.amag >= {2'b00, cfg.freefall_mg}) begin
					mode_d = MD_MONITOR;
				end
			end
			MD_VERIFY: begin
				if (delta_s1 >= {14'd0, immo_ms_q}) begin
					if (cur_s1.amag > STILL_LO_MG && cur_s1.amag < STILL_HI_MG &&
					    turn_q > {13'd0, cfg.orientation_mdeg}) begin
						mode_d  = MD_CONFIRMED;
						tally_d = tally_q + 32'd1;
						pulse_d = 1'b1;
						dur_d   = impact_q - ffstart_q;
					end else begin
						mode_d = MD_FALSE;
					end
				end else if ({cur_s1.amag, 1'b0} > {2'b00, cfg.impact_mg}) begin
					if (cur_s1.amag > peak_q) peak_d = cur_s1.amag;
					turn_d = turn_sum[32] ? '1 : turn_sum[31:0];
				end
			end
			MD_CONFIRMED: begin
				if (delta_s1 > {14'd0, hold_ms_q}) mode_d = MD_MONITOR;
			end
			MD_FALSE: mode_d = MD_MONITOR;
			default:  mode_d = MD_MONITOR;
		endcase
	end

	// Reported state code
	always_comb begin
		unique case (mode_d)
			MD_MONITOR:   code_d = DET_MONITOR;
			MD_FREEFALL:  code_d = DET_FREEFALL;
			MD_VERIFY:    code_d = DET_VERIFY;
			MD_CONFIRMED: code_d = DET_CONFIRMED;
			MD_FALSE:     code_d = DET_FALSE;
			default:      code_d = DET_MONITOR;
		endcase
	end

	// Control and detector state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bst_q       <= B_LOAD;
			mode_q      <= MD_MONITOR;
			ffstart_q   <= '0;
			impact_q    <= '0;
			peak_q      <= '0;
			turn_q      <= '0;
			tally_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a new result wins over the receiver taking the old one
			if (commit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (bst_q)
				B_LOAD: if (pop_valid) bst_q <= B_EVAL;
				B_EVAL: begin
					if (slot_free) begin
						bst_q     <= B_LOAD;
						mode_q    <= mode_d;
						ffstart_q <= ffstart_d;
						impact_q  <= impact_d;
						peak_q    <= peak_d;
						turn_q    <= turn_d;
						tally_q   <= tally_d;
					end
				end
				default: bst_q <= B_LOAD;
			endcase
		end
	end

	// Sample capture and elapsed time since impact
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_s1   <= pop_item;
			delta_s1 <= pop_item.time_ms - impact_q;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (commit) begin
			detector_state     <= code_d;
			fall_confirmed     <= pulse_d;
			accel_magnitude_mg <= cur_s1.amag;
			peak_impact_mg     <= peak_d;
			orientation_mdeg   <= turn_d;
			freefall_span_ms   <= dur_d;
			falls_total        <= tally_d;
		end
	end

endmodule

/* src/imu_fall_detector.sv */
// IMU fall detector, top level: configuration registers, front end,
// sample queue and back end. Depends on imu_fd_pkg, imu_fd_front,
// imu_fd_queue and imu_fd_back.
//
// Usage: one IMU sample (three accel axes, three gyro axes, timestamp) is
// one transaction on the input channel (in_valid/in_ready); each sample
// gives exactly one result transaction on the output channel
// (out_valid/out_ready) with the detector state and fall figures.
// Configuration is written through cfg_we/cfg_index/cfg_data, one register
// per cycle, while no sample is in flight; indexes above 4 are ignored.
// The front end accepts a sample, squares its six axes on one shared
// multiplier and sums them, takes two bit-serial square roots of 16 result
// bits, scales the gyro root with one multiply and pushes the item into the
// queue; it accepts no new sample until that push is done. The back end
// loads each sample from the queue and evaluates it once the output register
// is free, one sample at a time; out_valid rises when the result is written.
// A two-entry queue sits between front and back end, and the output
// register holds a finished result, so a stalled receiver holds up the
// input only once the output register, the back end and the queue are full.
// Reset (arst_n low) clears the detector state, counters, queue and
// handshakes and loads the configuration defaults.
module imu_fall_detector (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [imu_fd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [imu_fd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [15:0]                accel_x,
	input  logic signed [15:0]                accel_y,
	input  logic signed [15:0]                accel_z,
	input  logic signed [15:0]                rate_x,
	input  logic signed [15:0]                rate_y,
	input  logic signed [15:0]                rate_z,
	input  logic [31:0]                       time_ms,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [2:0]                        detector_state,
	output logic                              fall_confirmed,
	output logic [15:0]                       accel_magnitude_mg,
	output logic [15:0]                       peak_impact_mg,
	output logic [31:0]                       orientation_mdeg,
	output logic [31:0]                       freefall_span_ms,
	output logic [31:0]                       falls_total
);
	import imu_fd_pkg::*;

	cfg_t  cfg_q;
	logic  push;
	logic  push_ready;
	item_t push_item;
	logic  pop_valid;
	logic  pop;
	item_t pop_item;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.freefall_mg      <= FREEFALL_RST;
			cfg_q.impact_mg        <= IMPACT_RST;
			cfg_q.orientation_mdeg <= ORIENTATION_RST;
			cfg_q.immobility_s     <= IMMOBILITY_RST;
			cfg_q.hold_s           <= HOLD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FREEFALL:    cfg_q.freefall_mg      <= cfg_data[13:0];
				CFG_IMPACT:      cfg_q.impact_mg        <= cfg_data[14:0];
				CFG_ORIENTATION: cfg_q.orientation_mdeg <= cfg_data[18:0];
				CFG_IMMOBILITY:  cfg_q.immobility_s     <= cfg_data[7:0];
				CFG_HOLD:        cfg_q.hold_s           <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	imu_fd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.accel_x    (accel_x),
		.accel_y    (accel_y),
		.accel_z    (accel_z),
		.rate_x     (rate_x),
		.rate_y     (rate_y),
		.rate_z     (rate_z),
		.time_ms    (time_ms),
		.push       (push),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	imu_fd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_item   (pop_item)
	);

	imu_fd_back u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg                (cfg_q),
		.pop_valid          (pop_valid),
		.pop                (pop),
		.pop_item           (pop_item),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.detector_state     (detector_state),
		.fall_confirmed     (fall_confirmed),
		.accel_magnitude_mg (accel_magnitude_mg),
		.peak_impact_mg     (peak_impact_mg),
		.orientation_mdeg   (orientation_mdeg),
		.freefall_span_ms   (freefall_span_ms),
		.falls_total        (falls_total)
	);

endmodule
